// File: src/ppu_pkg.sv
// Package for the video processor CPU register port: command codes, register
// addresses, word structs and the control structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

  typedef enum logic [1:0] {
    CMD_READ       = 2'd0,
    CMD_WRITE      = 2'd1,
    CMD_FINE_Y     = 2'd2,
    CMD_SOFT_RESET = 2'd3
  } cmd_e;

  // decoded CPU addresses; everything else (mask, dma, mirrors) is ignored
  localparam logic [15:0] ADDR_CTRL     = 16'h2000;
  localparam logic [15:0] ADDR_STATUS   = 16'h2002;
  localparam logic [15:0] ADDR_OAM_ADDR = 16'h2003;
  localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
  localparam logic [15:0] ADDR_SCROLL   = 16'h2005;
  localparam logic [15:0] ADDR_ADDR     = 16'h2006;
  localparam logic [15:0] ADDR_DATA     = 16'h2007;

  localparam logic [7:0] STATUS_RESET = 8'hA0;
  localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
  localparam logic [4:0] COARSE_Y_MAX      = 5'd31;
  localparam logic [2:0] FINE_Y_MAX        = 3'd7;
  localparam logic [14:0] INC_ACROSS = 15'd1;
  localparam logic [14:0] INC_DOWN   = 15'd32;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
    logic [7:0]  open_bus;
  } ppu_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic        write_toggle;
    logic [7:0]  oam_addr;
  } ppu_out_t;

  // architectural registers seen after a step
  typedef struct packed {
    logic [14:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic        write_toggle;
    logic [7:0]  oam_addr;
  } ppu_state_t;

  // video memory access issued by one word
  typedef struct packed {
    logic        we;
    logic        re;
    logic [14:0] addr;
    logic [7:0]  wdata;
  } ppu_ram_req_t;

  // read result from the register file; ram_sel picks the memory data instead
  typedef struct packed {
    logic       ram_sel;
    logic [7:0] data;
  } ppu_read_t;

endpackage

`default_nettype wire

// File: src/ppu_vram.sv
// Video memory: single port, one access per cycle, registered read data.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ppu_vram #(
  parameter int ADDR_BITS = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] addr_i,
  input  wire logic [7:0]           wdata_i,
  output logic      [7:0]           rdata_o
);

  localparam int Depth = 1 << ADDR_BITS;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/ppu_regs.sv
// Register file of the port: t, v, fine x, write toggle, control, status and
// object registers, with the per-word update logic. Uses ppu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppu_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire ppu_pkg::ppu_in_t item_i,
  output ppu_pkg::ppu_state_t   state_o,
  output ppu_pkg::ppu_read_t    read_o,
  output ppu_pkg::ppu_ram_req_t ram_req_o
);

  import ppu_pkg::*;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  oam_addr_q, oam_addr_d;
  logic [7:0]  oam_data_q, oam_data_d;
  logic [14:0] temp_q, temp_d;
  logic [14:0] vaddr_q, vaddr_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;

  ppu_read_t    read_d;
  ppu_ram_req_t ram_req;

  logic [7:0] wd;
  logic [2:0] fine_y;
  logic [4:0] coarse_y;

  assign wd       = item_i.write_data;
  assign fine_y   = vaddr_q[14:12];
  assign coarse_y = vaddr_q[9:5];

  always_comb begin
    ctrl_d     = ctrl_q;
    status_d   = status_q;
    oam_addr_d = oam_addr_q;
    oam_data_d = oam_data_q;
    temp_d     = temp_q;
    vaddr_d    = vaddr_q;
    fine_x_d   = fine_x_q;
    toggle_d   = toggle_q;
    read_d     = '0;
    ram_req    = '0;
    ram_req.addr  = vaddr_q;
    ram_req.wdata = wd;

    unique case (item_i.cmd)
      CMD_READ: begin
        unique case (item_i.bus_addr)
          ADDR_STATUS: begin
            read_d.data = status_q;
            status_d    = {1'b0, status_q[6:0]};
            toggle_d    = 1'b0;
          end
          ADDR_OAM_DATA: read_d.data = oam_data_q;
          ADDR_DATA: begin
            read_d.ram_sel = 1'b1;
            ram_req.re     = 1'b1;
          end
          default: read_d.data = item_i.open_bus;
        endcase
      end
      CMD_WRITE: begin
        unique case (item_i.bus_addr)
          ADDR_CTRL: begin
            ctrl_d        = wd;
            temp_d[11:10] = wd[1:0];
          end
          ADDR_OAM_ADDR: oam_addr_d = wd;
          ADDR_OAM_DATA: begin
            oam_data_d = wd;
            oam_addr_d = oam_addr_q + 8'd1;
          end
          ADDR_SCROLL: begin
            if (!toggle_q) begin
              temp_d[4:0] = wd[7:3];
              fine_x_d    = wd[2:0];
            end else begin
              temp_d[9:5]   = wd[7:3];
              temp_d[14:12] = wd[2:0];
            end
            toggle_d = ~toggle_q;
          end
          ADDR_ADDR: begin
            if (!toggle_q) begin
              temp_d = {1'b0, wd[5:0], temp_q[7:0]};
            end else begin
              temp_d  = {temp_q[14:8], wd};
              vaddr_d = {temp_q[14:8], wd};
            end
            toggle_d = ~toggle_q;
          end
          ADDR_DATA: begin
            ram_req.we = 1'b1;
            vaddr_d    = vaddr_q + (ctrl_q[2] ? INC_DOWN : INC_ACROSS);
          end
          default: ;
        endcase
      end
      CMD_FINE_Y: begin
        if (fine_y != FINE_Y_MAX) begin
          vaddr_d[14:12] = fine_y + 3'd1;
        end else begin
          vaddr_d[14:12] = 3'd0;
          if (coarse_y == COARSE_Y_LAST_ROW) begin
            vaddr_d[9:5] = 5'd0;
            vaddr_d[11]  = ~vaddr_q[11];
          end else if (coarse_y == COARSE_Y_MAX) begin
            vaddr_d[9:5] = 5'd0;
          end else begin
            vaddr_d[9:5] = coarse_y + 5'd1;
          end
        end
      end
      CMD_SOFT_RESET: begin
        ctrl_d   = 8'd0;
        status_d = {1'b1, status_q[6:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= 8'd0;
      status_q   <= STATUS_RESET;
      oam_addr_q <= 8'd0;
      oam_data_q <= 8'd0;
      temp_q     <= 15'd0;
      vaddr_q    <= 15'd0;
      fine_x_q   <= 3'd0;
      toggle_q   <= 1'b0;
    end else if (accept_i) begin
      ctrl_q     <= ctrl_d;
      status_q   <= status_d;
      oam_addr_q <= oam_addr_d;
      oam_data_q <= oam_data_d;
      temp_q     <= temp_d;
      vaddr_q    <= vaddr_d;
      fine_x_q   <= fine_x_d;
      toggle_q   <= toggle_d;
    end
  end

  assign state_o.vram_addr    = vaddr_q;
  assign state_o.temp_addr    = temp_q;
  assign state_o.fine_x       = fine_x_q;
  assign state_o.write_toggle = toggle_q;
  assign state_o.oam_addr     = oam_addr_q;

  assign read_o = read_d;

  always_comb begin
    ram_req_o    = ram_req;
    ram_req_o.we = ram_req.we & accept_i;
    ram_req_o.re = ram_req.re & accept_i;
  end

endmodule

`default_nettype wire

// File: src/ppu_cpu_register_port_unit.sv
// Top level of the video processor CPU register port.
// Instantiates ppu_regs and ppu_vram; uses ppu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One word is accepted every cycle while the consumer keeps up, and its result
// is presented from the output register: the register update and the video
// memory access happen at the accept edge, the memory's registered read data
// joins the result in the result stage, and an output register holds it for the
// consumer. With the consumer stalled the block still takes one more word
// before in_ready_o drops. Results leave in order, one per word. Video memory
// has no reset; reading a location never written returns undefined data.
module ppu_cpu_register_port_unit #(
  parameter int VRAM_ADDR_BITS = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ppu_pkg::ppu_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ppu_pkg::ppu_out_t      out_data_o
);

  import ppu_pkg::*;

  logic         accept;
  logic         s1_adv;
  logic         s1_valid_q, s1_valid_d;
  logic         out_valid_q, out_valid_d;
  ppu_read_t    s1_read_q;
  ppu_out_t     out_data_q;
  ppu_state_t   state;
  ppu_read_t    read;
  ppu_ram_req_t ram_req;
  logic [7:0]   ram_rdata;

  ppu_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_data_i),
    .state_o   (state),
    .read_o    (read),
    .ram_req_o (ram_req)
  );

  ppu_vram #(
    .ADDR_BITS (VRAM_ADDR_BITS)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr[VRAM_ADDR_BITS-1:0]),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // result stage moves on whenever the output register is free or drains
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // the register file itself holds the result state of the word in the
  // result stage, since no new word updates it until that stage moves on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q <= read;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q.read_data    <= s1_read_q.ram_sel ? ram_rdata : s1_read_q.data;
      out_data_q.vram_addr    <= state.vram_addr;
      out_data_q.temp_addr    <= state.temp_addr;
      out_data_q.fine_x       <= state.fine_x;
      out_data_q.write_toggle <= state.write_toggle;
      out_data_q.oam_addr     <= state.oam_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // a word in the result stage is never dropped while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("result stage lost a word under stall");

  // no new word may overwrite a held result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_ready_o)
    else $error("input accepted while result stage was held");

  // at most one memory access per word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("video memory read and write in the same cycle");

  // the output register is filled only from a valid result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !s1_valid_q) |=> !out_valid_q)
    else $error("output became valid without a result");
`endif

endmodule

`default_nettype wire
